// ===== design/cld_pkg.sv =====
// Shared definitions for the circular list deque: operation and status codes,
// read address selects, and the controller/datapath command and status structs.
// No dependencies.
`default_nettype none

package cld_pkg;

   localparam int DEPTH_DEF      = 16;
   localparam int DATA_WIDTH_DEF = 32;

   // Request operation codes.
   localparam logic [2:0] FN_PUSH_FRONT = 3'd0;
   localparam logic [2:0] FN_PUSH_BACK  = 3'd1;
   localparam logic [2:0] FN_POP_FRONT  = 3'd2;
   localparam logic [2:0] FN_POP_BACK   = 3'd3;
   localparam logic [2:0] FN_REMOVE     = 3'd4;
   localparam logic [2:0] FN_SEARCH     = 3'd5;

   // Result status codes.
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_FULL      = 2'd1;
   localparam logic [1:0] ST_EMPTY     = 2'd2;
   localparam logic [1:0] ST_NOT_FOUND = 2'd3;

   // Memory read address selects.
   localparam logic [1:0] RD_FRONT = 2'd0;
   localparam logic [1:0] RD_BACK  = 2'd1;
   localparam logic [1:0] RD_INDEX = 2'd2;

   typedef struct packed {
      logic       load;
      logic       push_front;
      logic       push_back;
      logic       pop_front;
      logic       pop_back;
      logic [1:0] rd_sel;
      logic       take_out;
      logic       scan;
      logic       take_hit;
      logic       shift;
      logic       set_status;
      logic [1:0] status_code;
      logic       finish;
   } cmd_type;

   typedef struct packed {
      logic [2:0] func;
      logic       empty;
      logic       full;
      logic       hit;
      logic       scan_end;
      logic       shift_done;
   } sts_type;

endpackage

`default_nettype wire

// ===== design/cld_ctrl.sv =====
// Controller state machine for the circular list deque.
// Depends on cld_pkg for the command and status structs and the codes.
`default_nettype none

module cld_ctrl
   import cld_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire sts_type sts,
   output cmd_type      cmd
);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_DISPATCH = 3'd1;
   localparam logic [2:0] S_TAKE     = 3'd2;
   localparam logic [2:0] S_SCAN     = 3'd3;
   localparam logic [2:0] S_SHIFT    = 3'd4;
   localparam logic [2:0] S_DONE     = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      cmd      = '0;
      cmd.rd_sel = RD_INDEX;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            state_in = S_DONE;
            unique case (sts.func) inside
               FN_PUSH_FRONT, FN_PUSH_BACK: begin
                  if (sts.full) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = ST_FULL;
                  end else if (sts.func == FN_PUSH_FRONT) begin
                     cmd.push_front = 1'b1;
                  end else begin
                     cmd.push_back = 1'b1;
                  end
               end
               FN_POP_FRONT, FN_POP_BACK: begin
                  cmd.rd_sel = (sts.func == FN_POP_FRONT) ? RD_FRONT : RD_BACK;
                  if (sts.empty) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = ST_EMPTY;
                  end else begin
                     state_in = S_TAKE;
                  end
               end
               FN_REMOVE, FN_SEARCH: begin
                  if (sts.empty) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = (sts.func == FN_REMOVE) ? ST_EMPTY : ST_NOT_FOUND;
                  end else begin
                     state_in = S_SCAN;
                  end
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_TAKE: begin
            cmd.take_out = 1'b1;
            if (sts.func == FN_POP_FRONT) begin
               cmd.pop_front = 1'b1;
            end else begin
               cmd.pop_back = 1'b1;
            end
            state_in = S_DONE;
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.hit) begin
               cmd.take_hit = 1'b1;
               if (sts.func == FN_REMOVE) begin
                  cmd.take_out = 1'b1;
                  state_in     = S_SHIFT;
               end else begin
                  state_in = S_DONE;
               end
            end else if (sts.scan_end) begin
               cmd.set_status  = 1'b1;
               cmd.status_code = ST_NOT_FOUND;
               state_in        = S_DONE;
            end
         end
         S_SHIFT: begin
            cmd.shift = 1'b1;
            if (sts.shift_done) begin
               cmd.pop_back = 1'b1;
               state_in     = S_DONE;
            end
         end
         S_DONE: begin
            cmd.finish = 1'b1;
            state_in   = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== design/cld_datapath.sv =====
// Datapath of the circular list deque: entry memory, ring pointers, scan and
// gap-closing indexes, and result registers. Depends on cld_pkg.
`default_nettype none

module cld_datapath
   import cld_pkg::*;
#(
   parameter int DEPTH      = DEPTH_DEF,
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire cmd_type            cmd,
   output sts_type                 sts,
   input  wire logic [2:0]         req_func,
   input  wire logic signed [31:0] req_value,
   output logic                    rsp_strobe,
   output logic [1:0]              rsp_status,
   output logic signed [31:0]      rsp_value_out,
   output logic                    rsp_found,
   output logic [3:0]              rsp_position,
   output logic [4:0]              rsp_count
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [DATA_WIDTH-1:0] mem [DEPTH];

   logic [AW-1:0]         front_ff, front_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [2:0]            func_ff, func_in;
   logic [DATA_WIDTH-1:0] val_ff, val_in;
   logic [1:0]            status_ff, status_in;
   logic [31:0]           vout_ff, vout_in;
   logic                  found_ff, found_in;
   logic [3:0]            pos_ff, pos_in;
   logic [CW-1:0]         ridx_ff, ridx_in;
   logic [AW-1:0]         widx_ff, widx_in;
   logic [AW-1:0]         cmp_idx_ff, cmp_idx_in;
   logic                  cmp_vld_ff, cmp_vld_in;
   logic                  wr_pend_ff, wr_pend_in;
   logic                  strobe_ff;
   logic [DATA_WIDTH-1:0] rd_data_ff;

   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic [DATA_WIDTH-1:0] wr_data;
   logic [AW-1:0]         rd_addr;
   logic [AW-1:0]         front_dec, front_inc;
   logic signed [63:0]    req_wide;
   logic signed [DATA_WIDTH-1:0] rd_signed;
   logic signed [63:0]    rd_wide;
   logic                  equal;

   // Ring slot of the entry at a given offset from the front; the sum stays
   // below twice the depth, so one compare and subtract folds it back.
   function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                             input logic [CW-1:0] off);
      logic [CW:0] sum;
      sum = (CW+1)'(base) + (CW+1)'(off);
      if (sum >= (CW+1)'(DEPTH)) begin
         sum = sum - (CW+1)'(DEPTH);
      end
      return sum[AW-1:0];
   endfunction

   assign front_dec = (front_ff == '0) ? AW'(DEPTH - 1) : front_ff - AW'(1);
   assign front_inc = (front_ff == AW'(DEPTH - 1)) ? '0 : front_ff + AW'(1);
   assign req_wide  = 64'(req_value);
   assign rd_signed = rd_data_ff;
   assign rd_wide   = 64'(rd_signed);
   assign equal     = (rd_data_ff == val_ff);

   always_comb begin
      unique case (cmd.rd_sel)
         RD_FRONT: rd_addr = front_ff;
         RD_BACK:  rd_addr = slot_of(front_ff, count_ff - CW'(1));
         default:  rd_addr = slot_of(front_ff, ridx_ff);
      endcase
   end

   assign wr_en   = cmd.push_front | cmd.push_back | wr_pend_ff;
   assign wr_data = wr_pend_ff ? rd_data_ff : val_ff;

   always_comb begin
      if (cmd.push_front) begin
         wr_addr = front_dec;
      end else if (cmd.push_back) begin
         wr_addr = slot_of(front_ff, count_ff);
      end else begin
         wr_addr = slot_of(front_ff, CW'(widx_ff));
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_comb begin
      front_in   = front_ff;
      count_in   = count_ff;
      func_in    = func_ff;
      val_in     = val_ff;
      status_in  = status_ff;
      vout_in    = vout_ff;
      found_in   = found_ff;
      pos_in     = pos_ff;
      ridx_in    = ridx_ff;
      widx_in    = widx_ff;
      cmp_idx_in = cmp_idx_ff;
      cmp_vld_in = 1'b0;
      wr_pend_in = 1'b0;

      if (cmd.load) begin
         func_in   = req_func;
         val_in    = req_wide[DATA_WIDTH-1:0];
         status_in = ST_OK;
         vout_in   = '0;
         found_in  = 1'b0;
         pos_in    = '0;
         ridx_in   = '0;
      end
      if (cmd.push_front) begin
         front_in = front_dec;
         count_in = count_ff + CW'(1);
      end
      if (cmd.push_back) begin
         count_in = count_ff + CW'(1);
      end
      if (cmd.pop_front) begin
         front_in = front_inc;
         count_in = count_ff - CW'(1);
      end
      if (cmd.pop_back) begin
         count_in = count_ff - CW'(1);
      end
      if (cmd.take_out) begin
         vout_in = rd_wide[31:0];
      end
      if (cmd.set_status) begin
         status_in = cmd.status_code;
      end
      if (cmd.scan && (ridx_ff < count_ff)) begin
         ridx_in    = ridx_ff + CW'(1);
         cmp_vld_in = 1'b1;
         cmp_idx_in = ridx_ff[AW-1:0];
      end
      if (cmd.take_hit) begin
         found_in = 1'b1;
         pos_in   = 4'(cmp_idx_ff);
         widx_in  = cmp_idx_ff;
         ridx_in  = CW'(cmp_idx_ff) + CW'(1);
      end
      if (cmd.shift && (ridx_ff < count_ff)) begin
         ridx_in    = ridx_ff + CW'(1);
         wr_pend_in = 1'b1;
      end
      if (wr_pend_ff) begin
         widx_in = widx_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff   <= '0;
         count_ff   <= '0;
         cmp_vld_ff <= 1'b0;
         wr_pend_ff <= 1'b0;
         strobe_ff  <= 1'b0;
      end else begin
         front_ff   <= front_in;
         count_ff   <= count_in;
         cmp_vld_ff <= cmp_vld_in;
         wr_pend_ff <= wr_pend_in;
         strobe_ff  <= cmd.finish;
      end
   end

   always_ff @(posedge clock) begin
      func_ff    <= func_in;
      val_ff     <= val_in;
      status_ff  <= status_in;
      vout_ff    <= vout_in;
      found_ff   <= found_in;
      pos_ff     <= pos_in;
      ridx_ff    <= ridx_in;
      widx_ff    <= widx_in;
      cmp_idx_ff <= cmp_idx_in;
   end

   always_comb begin
      sts.func       = func_ff;
      sts.empty      = (count_ff == '0);
      sts.full       = (count_ff == CW'(DEPTH));
      sts.hit        = cmp_vld_ff && equal;
      sts.scan_end   = cmp_vld_ff && !equal && ((CW'(cmp_idx_ff) + CW'(1)) == count_ff);
      sts.shift_done = (ridx_ff >= count_ff) && !wr_pend_ff;
   end

   assign rsp_strobe    = strobe_ff;
   assign rsp_status    = status_ff;
   assign rsp_value_out = vout_ff;
   assign rsp_found     = found_ff;
   assign rsp_position  = pos_ff;
   assign rsp_count     = 5'(count_ff);

endmodule

`default_nettype wire

// ===== design/circular_list_deque_with_search_top.sv =====
// Top level of the circular list deque with search: controller plus datapath.
// Depends on cld_pkg, cld_ctrl and cld_datapath.
`default_nettype none

// The block keeps up to DEPTH signed values in order from front to back in a
// ring held in a single-port-read memory. A request is taken when start is
// high while busy is low; exactly one result follows, shown for one cycle
// with rsp_strobe high, and the receiver cannot hold it off. Pushes, and
// pops, searches or removals on an empty store, go from dispatch to done; a
// pop also passes a take state. A search reads one entry per cycle through
// the memory read port until it finds a match or passes the back entry. A
// removal by value then moves every later entry up by one, one entry per
// cycle over the same read port, before the result is shown.
// busy drops in the cycle the result is shown, so the next request may be
// taken in that very cycle. There is no clearing pass after reset.

module circular_list_deque_with_search_top
   import cld_pkg::*;
#(
   parameter int DEPTH      = DEPTH_DEF,
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [2:0]         req_func,
   input  wire logic signed [31:0] req_value,
   output logic                    rsp_strobe,
   output logic [1:0]              rsp_status,
   output logic signed [31:0]      rsp_value_out,
   output logic                    rsp_found,
   output logic [3:0]              rsp_position,
   output logic [4:0]              rsp_count
);

   cmd_type cmd;
   sts_type sts;

   // The controller sequences each request; the datapath owns all storage.
   cld_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   cld_datapath #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .req_func      (req_func),
      .req_value     (req_value),
      .rsp_strobe    (rsp_strobe),
      .rsp_status    (rsp_status),
      .rsp_value_out (rsp_value_out),
      .rsp_found     (rsp_found),
      .rsp_position  (rsp_position),
      .rsp_count     (rsp_count)
   );

   // A result is only shown once the controller has gone back to idle.
   assert property (@(posedge clock) disable iff (reset) rsp_strobe |-> !busy)
      else $error("result shown while busy");

   // A taken request never produces a result in the following cycle.
   assert property (@(posedge clock) disable iff (reset) cmd.load |=> (busy && !rsp_strobe))
      else $error("result too early after request");

   // Only one result per request: the strobe does not repeat back to back.
   assert property (@(posedge clock) disable iff (reset) rsp_strobe |=> !rsp_strobe)
      else $error("result strobe repeated");

   // A match always reports a good status.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_found) |-> (rsp_status == ST_OK))
      else $error("match reported with bad status");

endmodule

`default_nettype wire
